// ===== design/tglm_pkg.sv =====
// ----------------------------------------------------------------------------
// tglm_pkg: shared types and constants for the tape gap length measurer
// phase and operation codes, register indexes and register reset values
// ----------------------------------------------------------------------------
package tglm_pkg;

    // field widths
    localparam int unsigned DistW   = 32;
    localparam int unsigned CountW  = 5;
    localparam int unsigned CfgW    = 31;
    localparam int unsigned CfgIdxW = 2;

    // measurement phase
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_TAPE1   = 4'd1,
        PH_TAPE2   = 4'd2,
        PH_TAPE3   = 4'd3,
        PH_GAP1    = 4'd4,
        PH_GAP2    = 4'd5,
        PH_EXIT    = 4'd6,
        PH_DONE    = 4'd7,
        PH_TIMEOUT = 4'd8
    } t_phase;

    // word operation code
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ARM   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_CONFIRM_COUNT    = 2'd0,
        CFG_TIMEOUT_DISTANCE = 2'd1,
        CFG_TAPE_LEVEL       = 2'd2,
        CFG_GAP_LEVEL        = 2'd3
    } t_cfg_idx;

    // register reset values
    localparam logic [7:0]        RstConfirmCount    = 8'd1;
    localparam logic [CfgW-1:0]   RstTimeoutDistance = 31'd6400;
    localparam logic [CountW-1:0] RstTapeLevel       = 5'd5;
    localparam logic [CountW-1:0] RstGapLevel        = 5'd2;

endpackage

// ===== design/tape_gap_length_measurer.sv =====
// ----------------------------------------------------------------------------
// tape_gap_length_measurer: measures two white gaps between three tape strips
// path: an accepted input word is held in the input register, and its result word
//   is then registered in the result register
// throughput: one word per cycle while the result side takes words; the state
//   update is a single pass between the input register and the result register
// reset: synchronous active-low i_rst_n clears both stages and all state and
//   loads the register reset values; no clearing pass
// ----------------------------------------------------------------------------
module tape_gap_length_measurer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [tglm_pkg::CfgIdxW-1:0]         i_cfg_addr,
    input  logic [tglm_pkg::CfgW-1:0]            i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_operation,
    input  logic [tglm_pkg::CountW-1:0]          i_active_count,
    input  logic signed [tglm_pkg::DistW-1:0]    i_left_distance,
    input  logic signed [tglm_pkg::DistW-1:0]    i_right_distance,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [3:0]                           o_phase,
    output logic                                 o_seq_done,
    output logic                                 o_seq_timeout,
    output logic                                 o_exit_flag,
    output logic signed [tglm_pkg::DistW-1:0]    o_first_gap_length,
    output logic signed [tglm_pkg::DistW-1:0]    o_second_gap_length
);

    localparam int unsigned W = tglm_pkg::DistW;

    // configuration registers
    logic [7:0]                        r_confirm_count;
    logic [tglm_pkg::CfgW-1:0]         r_timeout_distance;
    logic [tglm_pkg::CountW-1:0]       r_tape_level;
    logic [tglm_pkg::CountW-1:0]       r_gap_level;

    // input stage
    logic                              r_in_valid;
    tglm_pkg::t_op                     r_in_op;
    logic [tglm_pkg::CountW-1:0]       r_in_active;
    logic signed [W-1:0]               r_in_dist;

    // measurement state
    tglm_pkg::t_phase                  r_phase;
    logic [7:0]                        r_counter;
    logic signed [W-1:0]               r_start_mark;
    logic signed [W-1:0]               r_gap_start;
    logic signed [W-1:0]               r_gap_one;
    logic signed [W-1:0]               r_gap_two;
    logic [2:0]                        r_flags;

    // result stage
    logic                              r_out_valid;
    tglm_pkg::t_phase                  r_out_phase;
    logic [2:0]                        r_out_flags;
    logic signed [W-1:0]               r_out_gap_one;
    logic signed [W-1:0]               r_out_gap_two;

    // next values
    tglm_pkg::t_phase                  n_phase;
    logic [7:0]                        n_counter;
    logic signed [W-1:0]               n_start_mark;
    logic signed [W-1:0]               n_gap_start;
    logic signed [W-1:0]               n_gap_one;
    logic signed [W-1:0]               n_gap_two;
    logic [2:0]                        n_flags;

    logic                              adv;
    logic signed [W:0]                 dist_sum;
    logic signed [W:0]                 travel;
    logic signed [W:0]                 gap_diff;
    logic signed [W-1:0]               gap_sat;
    logic                              timed_out;
    logic                              is_tape;
    logic                              is_gap;
    logic                              qual_ok;
    logic                              qual_hit;
    logic [7:0]                        cnt_inc;
    logic                              active_phase;

    // handshake: the input stage moves when the result stage is free or drains
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // floor average of the two encoder distances, taken at capture
    assign dist_sum = {i_left_distance[W-1], i_left_distance}
                    + {i_right_distance[W-1], i_right_distance};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm_count    <= tglm_pkg::RstConfirmCount;
            r_timeout_distance <= tglm_pkg::RstTimeoutDistance;
            r_tape_level       <= tglm_pkg::RstTapeLevel;
            r_gap_level        <= tglm_pkg::RstGapLevel;
        end else if (i_cfg_we) begin
            case (tglm_pkg::t_cfg_idx'(i_cfg_addr))
                tglm_pkg::CFG_CONFIRM_COUNT:    r_confirm_count    <= i_cfg_data[7:0];
                tglm_pkg::CFG_TIMEOUT_DISTANCE: r_timeout_distance <= i_cfg_data;
                tglm_pkg::CFG_TAPE_LEVEL:       r_tape_level <= i_cfg_data[tglm_pkg::CountW-1:0];
                tglm_pkg::CFG_GAP_LEVEL:        r_gap_level  <= i_cfg_data[tglm_pkg::CountW-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_op     <= tglm_pkg::t_op'(i_operation);
            r_in_active <= i_active_count;
            r_in_dist   <= dist_sum[W:1];
        end
    end

    // sensor classification and travel checks
    assign is_tape   = r_in_active >= r_tape_level;
    assign is_gap    = r_in_active <= r_gap_level;
    assign travel    = {r_in_dist[W-1], r_in_dist} - {r_start_mark[W-1], r_start_mark};
    assign timed_out = travel > $signed({2'b00, r_timeout_distance});
    assign gap_diff  = {r_in_dist[W-1], r_in_dist} - {r_gap_start[W-1], r_gap_start};
    assign cnt_inc   = r_counter + 8'd1;
    assign qual_hit  = cnt_inc >= r_confirm_count;

    assign active_phase = (r_phase != tglm_pkg::PH_IDLE) && (r_phase != tglm_pkg::PH_DONE)
                       && (r_phase != tglm_pkg::PH_TIMEOUT);

    // saturate the gap difference to the signed 32-bit range
    always_comb begin
        if (gap_diff[W] != gap_diff[W-1]) begin
            gap_sat = gap_diff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            gap_sat = gap_diff[W-1:0];
        end
    end

    // which sample qualifies in the current phase
    always_comb begin
        case (r_phase)
            tglm_pkg::PH_TAPE1,
            tglm_pkg::PH_TAPE2,
            tglm_pkg::PH_TAPE3: qual_ok = is_tape;
            default:            qual_ok = is_gap;
        endcase
    end

    // sequence logic
    always_comb begin
        n_phase      = r_phase;
        n_counter    = r_counter;
        n_start_mark = r_start_mark;
        n_gap_start  = r_gap_start;
        n_gap_one    = r_gap_one;
        n_gap_two    = r_gap_two;
        n_flags      = r_flags;
        case (r_in_op)
            tglm_pkg::OP_CLEAR: begin
                n_phase      = tglm_pkg::PH_IDLE;
                n_counter    = '0;
                n_start_mark = '0;
                n_gap_start  = '0;
                n_gap_one    = '0;
                n_gap_two    = '0;
                n_flags      = '0;
            end
            tglm_pkg::OP_ARM: begin
                if (r_phase == tglm_pkg::PH_IDLE) begin
                    n_phase      = tglm_pkg::PH_TAPE1;
                    n_counter    = '0;
                    n_flags      = '0;
                    n_start_mark = r_in_dist;
                    n_gap_start  = '0;
                    n_gap_one    = '0;
                    n_gap_two    = '0;
                end
            end
            tglm_pkg::OP_TICK: begin
                if (active_phase) begin
                    if (timed_out) begin
                        n_phase    = tglm_pkg::PH_TIMEOUT;
                        n_flags[1] = 1'b1;
                    end else if (!qual_ok) begin
                        n_counter = '0;
                    end else if (!qual_hit) begin
                        n_counter = cnt_inc;
                    end else begin
                        n_counter = '0;
                        case (r_phase)
                            tglm_pkg::PH_TAPE1: n_phase = tglm_pkg::PH_GAP1;
                            tglm_pkg::PH_GAP1: begin
                                n_gap_start = r_in_dist;
                                n_phase     = tglm_pkg::PH_TAPE2;
                            end
                            tglm_pkg::PH_TAPE2: begin
                                n_gap_one = gap_sat;
                                n_phase   = tglm_pkg::PH_GAP2;
                            end
                            tglm_pkg::PH_GAP2: begin
                                n_gap_start = r_in_dist;
                                n_phase     = tglm_pkg::PH_TAPE3;
                            end
                            tglm_pkg::PH_TAPE3: begin
                                n_gap_two = gap_sat;
                                n_phase   = tglm_pkg::PH_EXIT;
                            end
                            tglm_pkg::PH_EXIT: begin
                                n_flags[0] = 1'b1;
                                n_flags[2] = 1'b1;
                                n_phase    = tglm_pkg::PH_DONE;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tglm_pkg::PH_IDLE;
            r_counter    <= '0;
            r_start_mark <= '0;
            r_gap_start  <= '0;
            r_gap_one    <= '0;
            r_gap_two    <= '0;
            r_flags      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (adv) begin
                r_phase      <= n_phase;
                r_counter    <= n_counter;
                r_start_mark <= n_start_mark;
                r_gap_start  <= n_gap_start;
                r_gap_one    <= n_gap_one;
                r_gap_two    <= n_gap_two;
                r_flags      <= n_flags;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
        if (adv) begin
            r_out_phase   <= n_phase;
            r_out_flags   <= n_flags;
            r_out_gap_one <= n_gap_one;
            r_out_gap_two <= n_gap_two;
        end
    end

    // result word
    assign o_out_valid         = r_out_valid;
    assign o_phase             = r_out_phase;
    assign o_seq_done          = r_out_flags[0];
    assign o_seq_timeout       = r_out_flags[1];
    assign o_exit_flag         = r_out_flags[2];
    assign o_first_gap_length  = r_out_gap_one;
    assign o_second_gap_length = r_out_gap_two;

`ifndef SYNTHESIS
    // done flag marks exactly the done phase
    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_flags[0] == (r_out_phase == tglm_pkg::PH_DONE)))
        else $error("done flag disagrees with phase");

    // timeout flag marks exactly the timeout phase
    a_timeout_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_flags[1] == (r_out_phase == tglm_pkg::PH_TIMEOUT)))
        else $error("timeout flag disagrees with phase");

    // exit is only ever set together with done
    a_exit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags[2] == r_flags[0])
        else $error("exit flag and done flag differ");

    // a stalled input word stays in the input stage
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in_dist)))
        else $error("stalled input word lost");

    // state only moves when a word passes into the result stage
    a_state_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_phase))
        else $error("phase changed without an advancing word");
`endif

endmodule

// ===== bench/tape_gap_length_measurer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_gap_length_measurer_tb: regression bench for the tape gap measurer
// drives sample, arm, clear and no-op words through the valid/ready input channel,
// tracks the tape-gap-tape-gap-tape-exit sequence in a local model and checks
// every result word field by field, mostly under random idling on both channels
// ----------------------------------------------------------------------------
module tape_gap_length_measurer_tb;

    localparam longint DistMin = -64'sd2147483648;
    localparam longint DistMax = 64'sd2147483647;

    // dut ports
    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [tglm_pkg::CfgIdxW-1:0]        i_cfg_addr;
    logic [tglm_pkg::CfgW-1:0]           i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic [1:0]                          i_operation;
    logic [tglm_pkg::CountW-1:0]         i_active_count;
    logic signed [tglm_pkg::DistW-1:0]   i_left_distance;
    logic signed [tglm_pkg::DistW-1:0]   i_right_distance;
    logic                                o_out_valid;
    logic                                i_out_ready;
    logic [3:0]                          o_phase;
    logic                                o_seq_done;
    logic                                o_seq_timeout;
    logic                                o_exit_flag;
    logic signed [tglm_pkg::DistW-1:0]   o_first_gap_length;
    logic signed [tglm_pkg::DistW-1:0]   o_second_gap_length;

    // one expected result word
    typedef struct {
        tglm_pkg::t_phase phase;
        bit               done;
        bit               timed_out;
        bit               exited;
        int               gap_one;
        int               gap_two;
    } t_reading;

    t_reading expected_readings[$];

    // local copy of the registers
    logic [7:0]                  cfg_confirm;
    logic [tglm_pkg::CfgW-1:0]   cfg_timeout;
    logic [tglm_pkg::CountW-1:0] cfg_tape;
    logic [tglm_pkg::CountW-1:0] cfg_gap;

    // local copy of the measurement state
    tglm_pkg::t_phase trk_phase;
    logic [7:0]       trk_run;
    longint           trk_start;
    longint           trk_gap_start;
    int               trk_gap_one;
    int               trk_gap_two;
    bit               trk_done;
    bit               trk_timeout;
    bit               trk_exit;

    bit          idling = 1'b1;
    int unsigned out_stall = 0;
    int unsigned words_sent = 0;
    int unsigned mismatches = 0;

    tape_gap_length_measurer u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_operation         (i_operation),
        .i_active_count      (i_active_count),
        .i_left_distance     (i_left_distance),
        .i_right_distance    (i_right_distance),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_phase             (o_phase),
        .o_seq_done          (o_seq_done),
        .o_seq_timeout       (o_seq_timeout),
        .o_exit_flag         (o_exit_flag),
        .o_first_gap_length  (o_first_gap_length),
        .o_second_gap_length (o_second_gap_length)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3ms;
        $display("tape_gap_length_measurer regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // gap tracker model
    // ------------------------------------------------------------------

    function automatic longint clamp32(longint v);
        if (v > DistMax) return DistMax;
        if (v < DistMin) return DistMin;
        return v;
    endfunction

    task automatic clear_tracker();
        trk_phase     = tglm_pkg::PH_IDLE;
        trk_run       = 8'd0;
        trk_start     = 0;
        trk_gap_start = 0;
        trk_gap_one   = 0;
        trk_gap_two   = 0;
        trk_done      = 1'b0;
        trk_timeout   = 1'b0;
        trk_exit      = 1'b0;
    endtask

    // one qualifying or breaking sample; high when the phase moves on
    function automatic bit confirm_step(bit ok);
        if (!ok) begin
            trk_run = 8'd0;
            return 1'b0;
        end
        trk_run = trk_run + 8'd1;
        if (trk_run >= cfg_confirm) begin
            trk_run = 8'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one accepted word and queue the result word it produces
    task automatic track_gaps(tglm_pkg::t_op op, logic [tglm_pkg::CountW-1:0] cnt,
                              int left, int right);
        longint   avg_pos;
        bit       on_tape;
        bit       on_gap;
        t_reading rd;
        avg_pos = (longint'(left) + longint'(right)) >>> 1;
        on_tape = cnt >= cfg_tape;
        on_gap  = cnt <= cfg_gap;
        case (op)
            tglm_pkg::OP_CLEAR: begin
                clear_tracker();
            end
            tglm_pkg::OP_ARM: begin
                if (trk_phase == tglm_pkg::PH_IDLE) begin
                    clear_tracker();
                    trk_phase = tglm_pkg::PH_TAPE1;
                    trk_start = avg_pos;
                end
            end
            tglm_pkg::OP_TICK: begin
                if (trk_phase != tglm_pkg::PH_IDLE && trk_phase != tglm_pkg::PH_DONE &&
                        trk_phase != tglm_pkg::PH_TIMEOUT) begin
                    if (avg_pos - trk_start > longint'({1'b0, cfg_timeout})) begin
                        trk_phase   = tglm_pkg::PH_TIMEOUT;
                        trk_timeout = 1'b1;
                    end else begin
                        case (trk_phase)
                            tglm_pkg::PH_TAPE1: if (confirm_step(on_tape)) begin
                                trk_phase = tglm_pkg::PH_GAP1;
                            end
                            tglm_pkg::PH_GAP1: if (confirm_step(on_gap)) begin
                                trk_gap_start = avg_pos;
                                trk_phase     = tglm_pkg::PH_TAPE2;
                            end
                            tglm_pkg::PH_TAPE2: if (confirm_step(on_tape)) begin
                                trk_gap_one = int'(clamp32(avg_pos - trk_gap_start));
                                trk_phase   = tglm_pkg::PH_GAP2;
                            end
                            tglm_pkg::PH_GAP2: if (confirm_step(on_gap)) begin
                                trk_gap_start = avg_pos;
                                trk_phase     = tglm_pkg::PH_TAPE3;
                            end
                            tglm_pkg::PH_TAPE3: if (confirm_step(on_tape)) begin
                                trk_gap_two = int'(clamp32(avg_pos - trk_gap_start));
                                trk_phase   = tglm_pkg::PH_EXIT;
                            end
                            tglm_pkg::PH_EXIT: if (confirm_step(on_gap)) begin
                                trk_done  = 1'b1;
                                trk_exit  = 1'b1;
                                trk_phase = tglm_pkg::PH_DONE;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
        rd.phase     = trk_phase;
        rd.done      = trk_done;
        rd.timed_out = trk_timeout;
        rd.exited    = trk_exit;
        rd.gap_one   = trk_gap_one;
        rd.gap_two   = trk_gap_two;
        expected_readings.push_back(rd);
    endtask

    // ------------------------------------------------------------------
    // channel drivers and result checker
    // ------------------------------------------------------------------

    // result side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (out_stall != 0) begin
            i_out_ready <= 1'b0;
            out_stall = out_stall - 1;
        end else if (idling && $urandom_range(0, 4) == 0) begin
            i_out_ready <= 1'b0;
            out_stall = $urandom_range(0, 8);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_readings.size() == 0) begin
                $error("result word with no expectation pending");
                mismatches++;
            end else begin
                want = expected_readings.pop_front();
                if (o_phase !== want.phase) begin
                    $error("phase: expected %0d, actual %0d", want.phase, o_phase);
                    mismatches++;
                end
                if (o_seq_done !== want.done) begin
                    $error("seq_done: expected %0d, actual %0d", want.done, o_seq_done);
                    mismatches++;
                end
                if (o_seq_timeout !== want.timed_out) begin
                    $error("seq_timeout: expected %0d, actual %0d",
                           want.timed_out, o_seq_timeout);
                    mismatches++;
                end
                if (o_exit_flag !== want.exited) begin
                    $error("exit_flag: expected %0d, actual %0d", want.exited, o_exit_flag);
                    mismatches++;
                end
                if (o_first_gap_length !== want.gap_one) begin
                    $error("first_gap_length: expected %0d, actual %0d",
                           want.gap_one, o_first_gap_length);
                    mismatches++;
                end
                if (o_second_gap_length !== want.gap_two) begin
                    $error("second_gap_length: expected %0d, actual %0d",
                           want.gap_two, o_second_gap_length);
                    mismatches++;
                end
            end
        end
    end

    // send one word; returns in the time step of its acceptance
    task automatic send_word(tglm_pkg::t_op op, int unsigned cnt, int left, int right);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_active_count   <= cnt[tglm_pkg::CountW-1:0];
        i_left_distance  <= left;
        i_right_distance <= right;
        do @(posedge i_clk); while (!o_in_ready);
        track_gaps(op, cnt[tglm_pkg::CountW-1:0], left, right);
        words_sent++;
    endtask

    // send a word whose averaged travel lands on pos, with random left/right split
    task automatic send_at(tglm_pkg::t_op op, int unsigned cnt, longint pos);
        longint      off;
        int unsigned odd;
        off = $urandom_range(0, 512);
        odd = $urandom_range(0, 1);
        send_word(op, cnt, int'(pos + off + odd), int'(pos - off));
    endtask

    // wait until every result word is back and the pipeline is empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write all four registers while the block is idle
    task automatic load_settings(int unsigned confirm, int unsigned limit,
                                 int unsigned tape, int unsigned gap);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= tglm_pkg::CFG_CONFIRM_COUNT;
        i_cfg_data <= tglm_pkg::CfgW'(confirm);
        @(posedge i_clk);
        i_cfg_addr <= tglm_pkg::CFG_TIMEOUT_DISTANCE;
        i_cfg_data <= tglm_pkg::CfgW'(limit);
        @(posedge i_clk);
        i_cfg_addr <= tglm_pkg::CFG_TAPE_LEVEL;
        i_cfg_data <= tglm_pkg::CfgW'(tape);
        @(posedge i_clk);
        i_cfg_addr <= tglm_pkg::CFG_GAP_LEVEL;
        i_cfg_data <= tglm_pkg::CfgW'(gap);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_confirm = confirm[7:0];
        cfg_timeout = limit[tglm_pkg::CfgW-1:0];
        cfg_tape    = tape[tglm_pkg::CountW-1:0];
        cfg_gap     = gap[tglm_pkg::CountW-1:0];
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    function automatic longint keep_in_range(longint p);
        if (p > DistMax - 1024) return DistMax - 1024;
        if (p < DistMin + 1024) return DistMin + 1024;
        return p;
    endfunction

    // full sequence with default registers, ignored arms, idle ticks, no-op
    task automatic test_default_sequence();
        send_word(tglm_pkg::OP_TICK, 16, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_word(tglm_pkg::OP_NONE, 0, 32'sh80000000, 32'sh80000000);
        send_at(tglm_pkg::OP_ARM, 7, 0);
        send_at(tglm_pkg::OP_ARM, 0, 5000);
        send_at(tglm_pkg::OP_TICK, 16, 20);
        send_at(tglm_pkg::OP_TICK, 3, 60);
        send_at(tglm_pkg::OP_TICK, 0, 100);
        send_at(tglm_pkg::OP_TICK, 5, 180);
        send_at(tglm_pkg::OP_TICK, 2, 200);
        send_at(tglm_pkg::OP_TICK, 9, 330);
        send_at(tglm_pkg::OP_TICK, 1, 400);
        send_at(tglm_pkg::OP_TICK, 16, 900000);
        send_at(tglm_pkg::OP_ARM, 3, 0);
        send_at(tglm_pkg::OP_CLEAR, 0, 0);
        // travel exactly at the limit holds, one past it times out
        send_at(tglm_pkg::OP_ARM, 3, 0);
        send_at(tglm_pkg::OP_TICK, 3, 6400);
        send_word(tglm_pkg::OP_TICK, 3, 6401, 6402);
        send_word(tglm_pkg::OP_TICK, 3, -3, 0);
        send_at(tglm_pkg::OP_CLEAR, 16, 0);
    endtask

    // confirm of zero, zero timeout, tape level 16 and gap level 0
    task automatic test_level_extremes();
        load_settings(0, 0, 16, 0);
        send_word(tglm_pkg::OP_ARM, 0, -5, -5);
        send_word(tglm_pkg::OP_TICK, 16, -5, -5);
        send_word(tglm_pkg::OP_TICK, 15, -6, -6);
        send_word(tglm_pkg::OP_TICK, 0, -6, -7);
        send_word(tglm_pkg::OP_TICK, 16, -4, -4);
        send_word(tglm_pkg::OP_CLEAR, 0, 0, 0);
    endtask

    // distances at the ends of the range: 33-bit sums and saturated gaps
    task automatic test_distance_extremes();
        load_settings(0, 32'h7FFFFFFF, 0, 16);
        send_word(tglm_pkg::OP_ARM, 8, 0, 0);
        send_word(tglm_pkg::OP_TICK, 0, 32'sh80000000, 32'sh80000000);
        send_word(tglm_pkg::OP_TICK, 16, 32'sh80000000, 32'sh80000000);
        send_word(tglm_pkg::OP_TICK, 31 & 16, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_word(tglm_pkg::OP_TICK, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_word(tglm_pkg::OP_TICK, 2, 32'sh80000000, 32'sh80000000);
        send_word(tglm_pkg::OP_TICK, 4, 32'sh7FFFFFFF, 32'sh80000000);
        send_word(tglm_pkg::OP_CLEAR, 0, 0, 0);
        send_word(tglm_pkg::OP_ARM, 0, 32'sh80000000, 32'sh80000000);
        send_word(tglm_pkg::OP_TICK, 8, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_word(tglm_pkg::OP_CLEAR, 0, 0, 0);
    endtask

    // largest confirm count: the phase moves on the 255th tape sample only
    task automatic test_long_confirm();
        load_settings(255, 6400, 5, 2);
        send_at(tglm_pkg::OP_ARM, 0, 0);
        repeat (255) send_at(tglm_pkg::OP_TICK, $urandom_range(5, 16), 0);
        send_at(tglm_pkg::OP_CLEAR, 0, 0);
    endtask

    task automatic pick_settings();
        int unsigned confirm;
        int unsigned limit;
        int unsigned tape;
        int unsigned gap;
        confirm = $urandom_range(0, 6);
        case ($urandom_range(0, 3))
            0: limit = $urandom_range(50, 600);
            1: limit = 6400;
            2: limit = $urandom_range(1000, 100000);
            default: limit = 32'h7FFFFFFF;
        endcase
        tape = $urandom_range(3, 16);
        gap  = $urandom_range(0, tape - 1);
        if ($urandom_range(0, 5) == 0) gap = $urandom_range(0, 16);
        load_settings(confirm, limit, tape, gap);
    endtask

    // one measurement run with random content, noise and early aborts
    task automatic run_measurement();
        longint      pos;
        int unsigned stage;
        int unsigned good;
        int unsigned need;
        int unsigned cnt;
        int unsigned stride;
        bit          want_tape;
        case ($urandom_range(0, 7))
            0: pos = DistMax - 1024 - $urandom_range(0, 100000);
            1: pos = DistMin + 1024 + $urandom_range(0, 100000);
            default: pos = longint'($urandom_range(0, 200000)) - 100000;
        endcase
        case ($urandom_range(0, 2))
            0: stride = 8;
            1: stride = 60;
            default: stride = 400;
        endcase
        if ($urandom_range(0, 9) != 0) begin
            send_at(tglm_pkg::OP_CLEAR, $urandom_range(0, 16), pos);
        end
        send_at(tglm_pkg::OP_ARM, $urandom_range(0, 16), pos);
        need = (cfg_confirm == 0) ? 1 : cfg_confirm;
        for (stage = 0; stage < 6; stage++) begin
            want_tape = (stage % 2) == 0;
            good = 0;
            while (good < need) begin
                if (trk_phase == tglm_pkg::PH_TIMEOUT || trk_phase == tglm_pkg::PH_IDLE) return;
                if ($urandom_range(0, 15) == 0) pos = pos - $urandom_range(0, stride);
                else pos = pos + $urandom_range(0, stride);
                pos = keep_in_range(pos);
                if ($urandom_range(0, 59) == 0) begin
                    // stray arm, clear or spare code in the middle of a run
                    send_at(tglm_pkg::t_op'($urandom_range(1, 3)), $urandom_range(0, 16), pos);
                end else if ($urandom_range(0, 9) == 0) begin
                    send_at(tglm_pkg::OP_TICK, $urandom_range(0, 16), pos);
                    good = 0;
                end else begin
                    if (want_tape) cnt = $urandom_range(cfg_tape, 16);
                    else cnt = $urandom_range(0, cfg_gap);
                    send_at(tglm_pkg::OP_TICK, cnt, pos);
                    good++;
                end
            end
        end
        repeat ($urandom_range(0, 2)) send_at(tglm_pkg::OP_TICK, $urandom_range(0, 16), pos);
    endtask

    // random settings, then measurements and noise words up to the quota
    task automatic test_random_runs(int unsigned quota);
        int unsigned stop_at;
        pick_settings();
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_word(tglm_pkg::t_op'($urandom_range(0, 3)), $urandom_range(0, 16),
                              $urandom, $urandom);
            end else begin
                run_measurement();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_addr       <= tglm_pkg::CFG_CONFIRM_COUNT;
        i_cfg_data       <= '0;
        i_in_valid       <= 1'b0;
        i_operation      <= tglm_pkg::OP_TICK;
        i_active_count   <= '0;
        i_left_distance  <= '0;
        i_right_distance <= '0;
        cfg_confirm = tglm_pkg::RstConfirmCount;
        cfg_timeout = tglm_pkg::RstTimeoutDistance;
        cfg_tape    = tglm_pkg::RstTapeLevel;
        cfg_gap     = tglm_pkg::RstGapLevel;
        clear_tracker();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_sequence();
        test_level_extremes();
        test_distance_extremes();
        test_long_confirm();
        repeat (4) test_random_runs(260);
        // last part: no idling on either side
        idling = 1'b0;
        test_random_runs(260);

        settle();
        if (mismatches == 0)
            $display("tape_gap_length_measurer regression: pass");
        else
            $display("tape_gap_length_measurer regression: fail");
        $finish;
    end

endmodule
